// ===== rtl/uhu_pkg.sv =====
// Shared constants, types and helpers for the universal hash unit.
// No dependencies; imported by every module of the block.
package uhu_pkg;

    localparam int KEY_BITS        = 32;
    localparam int BYTE_BITS       = 8;
    localparam int KEY_BYTES       = KEY_BITS / BYTE_BITS;
    localparam int TAB_DEPTH       = 1024;
    localparam int TAB_AW          = 10;
    localparam int BANK_DEPTH      = 256;
    localparam int BANK_AW         = 8;
    localparam int TAB_BANKS       = TAB_DEPTH / BANK_DEPTH;
    localparam int BANK_SEL_W      = TAB_AW - BANK_AW;
    localparam int OUT_BITS_W      = 6;
    localparam int BLOCK_COUNT_DEF = 4;
    localparam int PADDR_W         = 4;

    localparam logic [1:0] MODE_TAB   = 2'd0;
    localparam logic [1:0] MODE_MULSH = 2'd1;
    localparam logic [1:0] MODE_TOP   = 2'd2;

    localparam logic [1:0] REG_HASH_MODE   = 2'd0;
    localparam logic [1:0] REG_OUT_BITS    = 2'd1;
    localparam logic [1:0] REG_MULT_FACTOR = 2'd2;
    localparam logic [1:0] REG_ADD_OFFSET  = 2'd3;

    localparam logic [OUT_BITS_W-1:0] OUT_BITS_RST = 6'd16;
    localparam logic [OUT_BITS_W-1:0] OUT_BITS_MAX = 6'd32;

    // control word that travels with a hash transaction
    typedef struct packed {
        logic                  valid;
        logic [1:0]            mode;
        logic [OUT_BITS_W-1:0] n_bits;
    } t_stage_ctl;

    // clamp the programmed width to the key width
    function automatic logic [OUT_BITS_W-1:0] eff_bits(input logic [OUT_BITS_W-1:0] n);
        eff_bits = (n > OUT_BITS_MAX) ? OUT_BITS_MAX : n;
    endfunction

endpackage

// ===== rtl/uhu_tab_bank.sv =====
// One 256-word bank of the tabulation table, one write port and two
// registered read ports (one fixed at word 0). Depends on uhu_pkg.
module uhu_tab_bank
    import uhu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [BANK_AW-1:0]  i_wr_addr,
    input  logic [KEY_BITS-1:0] i_wr_data,
    input  logic [BANK_AW-1:0]  i_rd_addr,
    output logic [KEY_BITS-1:0] o_rd_data,
    output logic [KEY_BITS-1:0] o_rd_zero
);

    logic [KEY_BITS-1:0] r_mem [BANK_DEPTH];
    logic [KEY_BITS-1:0] r_rd_data;
    logic [KEY_BITS-1:0] r_rd_zero;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
        r_rd_zero <= r_mem[0];
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_zero = r_rd_zero;

endmodule

// ===== rtl/uhu_hash_final.sv =====
// Last two pipeline stages: mode select with the b-add, then the
// upper-bits shift or low-bits mask into the result register. Depends on uhu_pkg.
module uhu_hash_final
    import uhu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_stage_ctl          i_ctl,
    input  logic [KEY_BITS-1:0] i_tab_word,
    input  logic [KEY_BITS-1:0] i_prod,
    input  logic [KEY_BITS-1:0] i_add_offset,
    input  logic [KEY_BITS-1:0] i_key,
    output logic                o_valid,
    output logic [KEY_BITS-1:0] o_hash_value
);

    logic                  r_s3_valid;
    logic                  r_s3_upper;
    logic [OUT_BITS_W-1:0] r_s3_n;
    logic [KEY_BITS-1:0]   r_s3_word;
    logic                  n_s3_upper;
    logic [KEY_BITS-1:0]   n_s3_word;

    logic                  r_valid;
    logic [KEY_BITS-1:0]   r_hash_value;
    logic [KEY_BITS-1:0]   n_hash_value;
    logic [OUT_BITS_W-1:0] w_shamt;

    always_comb begin
        case (i_ctl.mode)
            MODE_TAB: begin
                n_s3_word  = i_tab_word;
                n_s3_upper = 1'b0;
            end
            MODE_MULSH: begin
                n_s3_word  = i_prod + i_add_offset;
                n_s3_upper = 1'b1;
            end
            MODE_TOP: begin
                n_s3_word  = i_key;
                n_s3_upper = 1'b1;
            end
            default: begin
                n_s3_word  = '0;
                n_s3_upper = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= i_ctl.valid;
        end
        r_s3_upper <= n_s3_upper;
        r_s3_n     <= i_ctl.n_bits;
        r_s3_word  <= n_s3_word;
    end

    // width 0 shifts by 32 and masks with 0, so both paths give zero
    assign w_shamt = OUT_BITS_MAX - r_s3_n;

    always_comb begin
        if (r_s3_upper) begin
            n_hash_value = r_s3_word >> w_shamt;
        end else begin
            n_hash_value = r_s3_word & ~({KEY_BITS{1'b1}} << r_s3_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_s3_valid;
        end
        r_hash_value <= n_hash_value;
    end

    assign o_valid      = r_valid;
    assign o_hash_value = r_hash_value;

endmodule

// ===== rtl/universal_hash_unit_core.sv =====
// Top level of the universal hash unit: APB register file, input stage,
// table banks, multiplier stage. Depends on uhu_pkg, uhu_tab_bank, uhu_hash_final.
//
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low. busy is held low: the pipeline never stalls, so one
//   transaction may be issued every cycle. req_type 0 hashes i_key,
//   req_type 1 writes i_entry_value into table word i_entry_index and gives
//   no result.
//   Result channel: o_valid marks o_hash_value for exactly one cycle; the
//   receiver cannot stall, so nothing backs up. A taken hash passes through
//   four register stages: input, table read / 32x32 multiply, mode select /
//   add, shift or mask. Throughput is one result per cycle.
//   A table write lands in the cycle after it is taken; a hash issued in the
//   very next cycle already reads the new word.
//   Config: APB registers at 0x0 hash_mode, 0x4 out_bits, 0x8 mult_factor,
//   0xC add_offset; pready is always high. Write them only while idle.
//   Reset: synchronous, active low; clears the pipeline and loads register
//   defaults. The table is not cleared and must be written before use.
module universal_hash_unit_core
    import uhu_pkg::*;
#(
    parameter int BLOCK_COUNT = BLOCK_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_req_type,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [TAB_AW-1:0]   i_entry_index,
    input  logic [KEY_BITS-1:0] i_entry_value,
    output logic                o_valid,
    output logic [KEY_BITS-1:0] o_hash_value,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // ---------------- configuration registers ----------------
    logic [1:0]            r_hash_mode;
    logic [OUT_BITS_W-1:0] r_out_bits;
    logic [KEY_BITS-1:0]   r_mult_factor;
    logic [KEY_BITS-1:0]   r_add_offset;
    logic                  w_cfg_wr;
    logic [1:0]            w_reg_sel;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign w_reg_sel = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_mode   <= MODE_TAB;
            r_out_bits    <= OUT_BITS_RST;
            r_mult_factor <= 32'd1;
            r_add_offset  <= '0;
        end else if (w_cfg_wr) begin
            case (w_reg_sel)
                REG_HASH_MODE:   r_hash_mode   <= pwdata[1:0];
                REG_OUT_BITS:    r_out_bits    <= pwdata[OUT_BITS_W-1:0];
                REG_MULT_FACTOR: r_mult_factor <= pwdata;
                REG_ADD_OFFSET:  r_add_offset  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_sel)
            REG_HASH_MODE:   prdata = {30'd0, r_hash_mode};
            REG_OUT_BITS:    prdata = {26'd0, r_out_bits};
            REG_MULT_FACTOR: prdata = r_mult_factor;
            REG_ADD_OFFSET:  prdata = r_add_offset;
            default:         prdata = '0;
        endcase
    end

    // ---------------- stage 1: input register ----------------
    logic                w_accept;
    t_stage_ctl          r_s1_ctl;
    logic                r_s1_wr;
    logic [KEY_BITS-1:0] r_s1_key;
    logic [TAB_AW-1:0]   r_s1_idx;
    logic [KEY_BITS-1:0] r_s1_val;

    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl.valid <= 1'b0;
            r_s1_wr        <= 1'b0;
        end else begin
            r_s1_ctl.valid <= w_accept & ~i_req_type;
            r_s1_wr        <= w_accept & i_req_type;
        end
        // user keeps config static while transactions are in flight; unenforced
        r_s1_ctl.mode   <= r_hash_mode;
        r_s1_ctl.n_bits <= eff_bits(r_out_bits);
        r_s1_key        <= i_key;
        r_s1_idx        <= i_entry_index;
        r_s1_val        <= i_entry_value;
    end

    // ---------------- stage 2: table read and multiply ----------------
    // Bank j holds table words j*256 .. j*256+255. Block j (j < 4) reads its
    // key byte from bank j; blocks 4..7 wrap onto bank j-4 at byte 0.
    logic [KEY_BITS-1:0] w_rd_data [TAB_BANKS];
    logic [KEY_BITS-1:0] w_rd_zero [TAB_BANKS];

    genvar j;
    generate
        for (j = 0; j < TAB_BANKS; j++) begin : g_bank
            uhu_tab_bank u_bank (
                .i_clk     (i_clk),
                .i_wr_en   (r_s1_wr && (r_s1_idx[TAB_AW-1:BANK_AW] == BANK_SEL_W'(j))),
                .i_wr_addr (r_s1_idx[BANK_AW-1:0]),
                .i_wr_data (r_s1_val),
                .i_rd_addr (r_s1_key[KEY_BITS-1-BYTE_BITS*j -: BYTE_BITS]),
                .o_rd_data (w_rd_data[j]),
                .o_rd_zero (w_rd_zero[j])
            );
        end
    endgenerate

    t_stage_ctl          r_s2_ctl;
    logic [KEY_BITS-1:0] r_s2_key;
    logic [KEY_BITS-1:0] r_prod;
    logic [KEY_BITS-1:0] n_prod;

    assign n_prod = KEY_BITS'(r_s1_key * r_mult_factor);  // mod 2^32

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl.valid <= 1'b0;
        end else begin
            r_s2_ctl.valid <= r_s1_ctl.valid;
        end
        r_s2_ctl.mode   <= r_s1_ctl.mode;
        r_s2_ctl.n_bits <= r_s1_ctl.n_bits;
        r_s2_key        <= r_s1_key;
        r_prod          <= n_prod;
    end

    // XOR of the table words picked by all blocks
    logic [KEY_BITS-1:0] w_tab_word;

    always_comb begin
        w_tab_word = '0;
        for (int b = 0; b < TAB_BANKS; b++) begin
            if (b < BLOCK_COUNT) begin
                w_tab_word = w_tab_word ^ w_rd_data[b];
            end
            if (b + TAB_BANKS < BLOCK_COUNT) begin
                w_tab_word = w_tab_word ^ w_rd_zero[b];
            end
        end
    end

    // ---------------- stages 3 and 4 ----------------
    uhu_hash_final u_final (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (r_s2_ctl),
        .i_tab_word   (w_tab_word),
        .i_prod       (r_prod),
        .i_add_offset (r_add_offset),
        .i_key        (r_s2_key),
        .o_valid      (o_valid),
        .o_hash_value (o_hash_value)
    );

endmodule

// ===== rtl/uhu_checker.sv =====
// Port-level checker for universal_hash_unit_core, with its bind.
// Depends on uhu_pkg and on the top level's port list.
module uhu_checker
    import uhu_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_req_type,
    input logic o_valid
);

    // a hash transaction is followed by a result on o_valid
    a_hash_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_req_type) |-> ##4 o_valid)
        else $error("hash transaction gave no result");

    // a table write yields no result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type) |-> ##4 !o_valid)
        else $error("table write gave a result");

    // every result traces back to a hash transaction
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && !i_req_type, 4))
        else $error("result without a hash transaction");

    // the pipeline never holds off commands
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

endmodule

bind universal_hash_unit_core uhu_checker u_uhu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_req_type (i_req_type),
    .o_valid    (o_valid)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for universal_hash_unit_core: command-port stimulus,
// APB register setup and an in-order compare of every hash against a local predictor.
// Depends on uhu_pkg and the universal_hash_unit_core RTL.
module testbench;
    import uhu_pkg::*;

    // unnamed fourth mode: block must answer with a zero hash
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;     // four-stage pipe plus table-write landing
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 60;

    // ---------------------------------------------------------------- DUT I/O
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                i_req_type = 1'b0;
    logic [KEY_BITS-1:0] i_key = '0;
    logic [TAB_AW-1:0]   i_entry_index = '0;
    logic [KEY_BITS-1:0] i_entry_value = '0;
    logic                o_valid;
    logic [KEY_BITS-1:0] o_hash_value;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    universal_hash_unit_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_key         (i_key),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .o_valid       (o_valid),
        .o_hash_value  (o_hash_value),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------- predictor state
    // Shadow copies of the registers, updated at the APB write edge.
    logic [1:0]            cfg_mode = MODE_TAB;
    logic [OUT_BITS_W-1:0] cfg_out_bits = OUT_BITS_RST;
    logic [31:0]           cfg_mult = 32'd1;
    logic [31:0]           cfg_add = 32'd0;

    // Table shadow. The RTL table powers up undefined, so we track which
    // words were written and only ever build tabulation keys that hit those.
    logic [31:0]           tab_mirror [TAB_DEPTH];
    bit                    table_written [TAB_DEPTH];

    logic [31:0]           expected_hashes [$];
    int                    mismatch_count = 0;
    int                    cycle_count = 0;
    bit                    gaps_enabled = 1'b1;
    logic [31:0]           want;

    // Expected hash for one key under the current register settings.
    function automatic logic [31:0] predict_hash(input logic [31:0] key);
        int          n_eff;
        int          blk;
        logic [7:0]  byte_val;
        logic [31:0] acc;
        logic [31:0] mask;
        logic [31:0] prod;
        n_eff = (cfg_out_bits > KEY_BITS) ? KEY_BITS : int'(cfg_out_bits);
        mask  = (n_eff == 0) ? '0 : (n_eff >= KEY_BITS) ? '1 : ((32'd1 << n_eff) - 32'd1);
        case (cfg_mode)
            MODE_TAB: begin
                // block 0 is the most significant key byte; blocks past the
                // key see byte 0 and the address wraps to the table size
                acc = '0;
                for (blk = 0; blk < BLOCK_COUNT_DEF; blk++) begin
                    byte_val = (blk < KEY_BYTES) ?
                               key[KEY_BITS-1-BYTE_BITS*blk -: BYTE_BITS] : 8'd0;
                    acc ^= tab_mirror[(blk*BANK_DEPTH + byte_val) % TAB_DEPTH];
                end
                return acc & mask;
            end
            MODE_MULSH: begin
                prod = cfg_mult * key + cfg_add;   // wraps mod 2^32
                return (n_eff == 0) ? '0 : (prod >> (KEY_BITS - n_eff));
            end
            MODE_TOP: return (n_eff == 0) ? '0 : (key >> (KEY_BITS - n_eff));
            default:  return '0;
        endcase
    endfunction

    // Move each key byte forward to the nearest written word of its block.
    function automatic logic [31:0] tab_safe_key(input logic [31:0] raw);
        logic [31:0] k;
        logic [7:0]  byte_val;
        int          blk;
        int          step;
        k = raw;
        for (blk = 0; blk < KEY_BYTES; blk++) begin
            byte_val = k[KEY_BITS-1-BYTE_BITS*blk -: BYTE_BITS];
            step = 0;
            while (!table_written[blk*BANK_DEPTH + byte_val] && step < BANK_DEPTH) begin
                byte_val++;
                step++;
            end
            k[KEY_BITS-1-BYTE_BITS*blk -: BYTE_BITS] = byte_val;
        end
        return k;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 32'h0;
            1:       return 32'h1;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OUT_BITS_W-1:0] pick_width();
        case ($urandom_range(0, 6))
            0:       return 6'd0;                    // zero width
            1:       return 6'd1;
            2:       return OUT_BITS_MAX;
            3:       return 6'($urandom_range(33, 63));  // clamps to 32
            default: return 6'($urandom_range(1, 32));
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("ERROR cycle %0d: %s", cycle_count, what);
    endtask

    // ----------------------------------------------------------- result side
    // The receiver cannot stall: every strobe is a transaction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                if (expected_hashes.size() == 0) begin
                    report_mismatch($sformatf("unexpected hash %h", o_hash_value));
                end else begin
                    want = expected_hashes.pop_front();
                    if (o_hash_value !== want)
                        report_mismatch($sformatf("hash_value got %h want %h",
                                                  o_hash_value, want));
                end
            end else if (o_valid !== 1'b0) begin
                report_mismatch("o_valid unknown");
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------ drivers
    task automatic apply_reset();
        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // One command transaction. start stays high when the next item follows
    // with no gap, so it is never lowered and raised in the same step.
    task automatic send_item(input logic req, input logic [31:0] key,
                             input logic [TAB_AW-1:0] idx, input logic [31:0] val);
        int gap;
        gap = gaps_enabled ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_req_type    <= req;
        i_key         <= key;
        i_entry_index <= idx;
        i_entry_value <= val;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        // accepted at this edge
        if (req) begin
            tab_mirror[idx]    = val;
            table_written[idx] = 1'b1;
        end else begin
            expected_hashes.push_back(predict_hash(key));
        end
    endtask

    task automatic write_table(input logic [TAB_AW-1:0] idx, input logic [31:0] val);
        send_item(1'b1, $urandom, idx, val);
    endtask

    task automatic hash_key(input logic [31:0] key);
        send_item(1'b0, key, TAB_AW'($urandom), $urandom);
    endtask

    // Let the pipe run dry; table writes have no result, hence the drain.
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_hashes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        case (idx)
            REG_HASH_MODE:   cfg_mode     = data[1:0];
            REG_OUT_BITS:    cfg_out_bits = data[OUT_BITS_W-1:0];
            REG_MULT_FACTOR: cfg_mult     = data;
            REG_ADD_OFFSET:  cfg_add      = data;
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [1:0] mode, input logic [OUT_BITS_W-1:0] nb,
                              input logic [31:0] mult, input logic [31:0] add);
        wait_idle();
        write_reg(REG_HASH_MODE, {30'd0, mode});
        write_reg(REG_OUT_BITS, {26'd0, nb});
        write_reg(REG_MULT_FACTOR, mult);
        write_reg(REG_ADD_OFFSET, add);
    endtask

    // -------------------------------------------------------------- tests
    // Corner words of every bank, then back-to-back write/hash so the
    // hash reads a word written the cycle before. Reset config: tab, 16 bits.
    task automatic test_table_extremes();
        gaps_enabled = 1'b0;
        write_table(10'd0,    32'hFFFF_FFFF);
        write_table(10'd256,  32'h0000_0000);
        write_table(10'd512,  32'hA5A5_A5A5);
        write_table(10'd768,  32'h5A5A_5A5A);
        write_table(10'd255,  32'h0000_0000);
        write_table(10'd511,  32'hFFFF_FFFF);
        write_table(10'd767,  32'h1234_5678);
        write_table(10'd1023, 32'hFFFF_FFFF);
        hash_key(32'h0000_0000);
        hash_key(32'hFFFF_FFFF);
        hash_key(32'hFF00_FF00);
        write_table(10'd1023, 32'h8000_0001);
        hash_key(32'hFFFF_FFFF);
        gaps_enabled = 1'b1;
    endtask

    // Multiply-shift wrap, top bits at width 1, and the unused mode.
    task automatic test_hash_modes();
        set_config(MODE_MULSH, OUT_BITS_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        hash_key(32'hFFFF_FFFF);
        hash_key(32'h0000_0000);
        set_config(MODE_TOP, 6'd1, 32'd0, 32'd0);
        hash_key(32'h8000_0000);
        hash_key(32'h7FFF_FFFF);
        set_config(MODE_UNUSED, OUT_BITS_MAX, 32'h9E37_79B9, 32'h1);
        hash_key(32'hFFFF_FFFF);
    endtask

    // Zero width and widths past the key.
    task automatic test_width_edges();
        set_config(MODE_TAB, 6'd0, 32'd1, 32'd0);
        hash_key(32'hFFFF_FFFF);
        set_config(MODE_TAB, 6'd63, 32'd1, 32'd0);
        hash_key(32'h00FF_00FF);
        set_config(MODE_MULSH, 6'd63, 32'h9E37_79B9, 32'h7F4A_7C15);
        hash_key(32'h9E37_79B9);
    endtask

    // Phases of mixed table writes and hashes, each under fresh registers.
    task automatic test_random_traffic();
        int          phase;
        int          item;
        logic [1:0]  mode;
        logic [31:0] raw;
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase < 4)
                mode = phase[1:0];
            else
                mode = ($urandom_range(0, 9) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
            set_config(mode, pick_width(), pick_word(), pick_word());
            gaps_enabled = ($urandom_range(0, 2) != 0);
            for (item = 0; item < PHASE_ITEMS; item++) begin
                if ($urandom_range(0, 3) == 0) begin
                    write_table(10'($urandom_range(0, TAB_DEPTH - 1)), pick_word());
                end else begin
                    raw = $urandom;
                    hash_key((cfg_mode == MODE_TAB) ? tab_safe_key(raw) : raw);
                end
            end
        end
        gaps_enabled = 1'b1;
    endtask

    // ------------------------------------------------------------- sequence
    initial begin
        apply_reset();
        test_table_extremes();
        test_hash_modes();
        test_width_edges();
        test_random_traffic();
        wait_idle();
        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
